/* sv/ffsa_pkg.sv */
package ffsa_pkg;

  localparam int SLOT_W        = 11;
  localparam int MAX_SLOTS_DEF = 1024;
  localparam logic [SLOT_W-1:0] CNT_RESET = SLOT_W'(1024);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic STAT_GRANTED = 1'b0;
  localparam logic STAT_FULL    = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] requested_slot;
  } ffsa_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] assigned_slot;
    logic              status;
  } ffsa_out_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic issue;
    logic rel_rd;
    logic rel_write;
    logic set_write;
    logic grant;
    logic full;
  } ffsa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic full;
    logic issue_done;
    logic rel_ok;
  } ffsa_sts_t;

endpackage

/* sv/ffsa_ctrl.sv */
module ffsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 func,
  input  ffsa_pkg::ffsa_sts_t  sts,
  output ffsa_pkg::ffsa_cmd_t  cmd,
  output logic                 busy
);
  import ffsa_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_REL_RD,
    ST_REL_WR
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = (func == FUNC_ALLOC) ? ST_SCAN : ST_REL_RD;
      end
      ST_SCAN: begin
        if (sts.hit) state_nxt = ST_WRITE;
        else if (sts.full) state_nxt = ST_IDLE;
      end
      ST_WRITE:  state_nxt = ST_IDLE;
      ST_REL_RD: state_nxt = sts.rel_ok ? ST_REL_WR : ST_IDLE;
      ST_REL_WR: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && start;
    cmd.clr_step  = (state_r == ST_CLEAR);
    // Reads stop as soon as a free slot shows up, so the hit word stays put.
    cmd.issue     = (state_r == ST_SCAN) && !sts.hit && !sts.issue_done;
    cmd.full      = (state_r == ST_SCAN) && sts.full;
    cmd.set_write = (state_r == ST_WRITE);
    cmd.grant     = (state_r == ST_WRITE);
    cmd.rel_rd    = (state_r == ST_REL_RD) && sts.rel_ok;
    cmd.rel_write = (state_r == ST_REL_WR);
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/ffsa_dp.sv */
module ffsa_dp #(
  parameter int MAX_SLOTS = ffsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [ffsa_pkg::SLOT_W-1:0]  cfg_data,
  input  ffsa_pkg::ffsa_in_t           in_data,
  input  ffsa_pkg::ffsa_cmd_t          cmd,
  output ffsa_pkg::ffsa_sts_t          sts,
  output logic                         out_valid,
  output ffsa_pkg::ffsa_out_t          out_data
);
  import ffsa_pkg::*;

  localparam int SW   = $clog2(MAX_SLOTS + 1);
  localparam int WL   = (SW > 5) ? 5 : SW - 1;
  localparam int WORD = 1 << WL;
  localparam int RW   = SW - WL;
  localparam int ROWS = (MAX_SLOTS >> WL) + 1;

  // Each memory row holds the occupied flags of WORD consecutive slots.
  logic [WORD-1:0] mem [ROWS];

  logic [SLOT_W-1:0] slot_count_r;
  logic [SW-1:0]     n_r;
  logic [SW-1:0]     start_r;
  logic [SW-1:0]     start_m1_r;
  logic              req_ok_r;
  logic              wrap_r;
  logic [RW-1:0]     row_r;
  logic              pass_r;
  logic              done_r;
  logic [RW-1:0]     clr_ptr_r;

  logic [WORD-1:0]   rd_data_r;
  logic              chk_v_r;
  logic [RW-1:0]     chk_row_r;
  logic              chk_pass_r;
  logic              chk_last_r;

  logic [RW-1:0]     win_row_r;
  logic [WORD-1:0]   win_word_r;
  logic [SW-1:0]     win_slot_r;

  logic              out_valid_r;
  ffsa_out_t         out_data_r;

  logic [SW-1:0]     n_c;
  logic              req_ok_c;
  logic [SW-1:0]     start_c;
  logic [RW-1:0]     end_row_c;
  logic              last_c;
  logic [RW-1:0]     rd_addr_c;
  logic [SW-1:0]     lo_c;
  logic [SW-1:0]     hi_c;
  logic [WORD-1:0]   mask_c;
  logic [WORD-1:0]   free_c;
  logic [WL-1:0]     hit_bit_c;
  logic              hit_c;
  logic              we_c;
  logic [RW-1:0]     wa_c;
  logic [WORD-1:0]   wd_c;

  // Active slot count, clamped to 1..MAX_SLOTS, and the search start slot.
  always_comb begin
    if (slot_count_r == '0) begin
      n_c = SW'(1);
    end else if (32'(slot_count_r) > MAX_SLOTS) begin
      n_c = SW'(MAX_SLOTS);
    end else begin
      n_c = SW'(slot_count_r);
    end
    req_ok_c = (in_data.requested_slot != '0) &&
               (32'(in_data.requested_slot) <= 32'(n_c));
    start_c  = req_ok_c ? SW'(in_data.requested_slot) : SW'(1);
  end

  // The first pass runs from the start slot to the top, the wrap pass from slot 1
  // up to just below the start slot.
  assign end_row_c = pass_r ? start_m1_r[SW-1:WL] : n_r[SW-1:WL];
  assign last_c    = (row_r == end_row_c) && (pass_r || !wrap_r);
  assign rd_addr_c = cmd.rel_rd ? start_r[SW-1:WL] : row_r;

  always_comb begin
    lo_c = chk_pass_r ? SW'(1) : start_r;
    hi_c = chk_pass_r ? start_m1_r : n_r;
    for (int b = 0; b < WORD; b++) begin
      mask_c[b] = ((chk_row_r != lo_c[SW-1:WL]) || (WL'(b) >= lo_c[WL-1:0])) &&
                  ((chk_row_r != hi_c[SW-1:WL]) || (WL'(b) <= hi_c[WL-1:0]));
    end
    free_c    = ~rd_data_r & mask_c;
    hit_bit_c = '0;
    for (int b = WORD - 1; b >= 0; b--) begin
      if (free_c[b]) hit_bit_c = WL'(b);
    end
    hit_c = chk_v_r && (free_c != '0);
  end

  always_comb begin
    we_c = 1'b0;
    wa_c = win_row_r;
    wd_c = win_word_r;
    if (cmd.clr_step) begin
      we_c = 1'b1;
      wa_c = clr_ptr_r;
      wd_c = '0;
    end else if (cmd.set_write) begin
      we_c = 1'b1;
    end else if (cmd.rel_write) begin
      we_c = 1'b1;
      wa_c = start_r[SW-1:WL];
      wd_c = rd_data_r & ~(WORD'(1) << start_r[WL-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (we_c) mem[wa_c] <= wd_c;
    if (cmd.issue || cmd.rel_rd) rd_data_r <= mem[rd_addr_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= CNT_RESET;
      clr_ptr_r    <= '0;
      chk_v_r      <= 1'b0;
      done_r       <= 1'b0;
      pass_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) slot_count_r <= cfg_data;
      if (cmd.clr_step) clr_ptr_r <= clr_ptr_r + RW'(1);
      chk_v_r     <= cmd.issue;
      out_valid_r <= cmd.grant || cmd.full;
      if (cmd.load) begin
        row_r  <= start_c[SW-1:WL];
        pass_r <= 1'b0;
        done_r <= 1'b0;
      end else if (cmd.issue) begin
        if (row_r == end_row_c) begin
          if (!pass_r && wrap_r) begin
            pass_r <= 1'b1;
            row_r  <= '0;
          end else begin
            done_r <= 1'b1;
          end
        end else begin
          row_r <= row_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r        <= n_c;
      start_r    <= start_c;
      start_m1_r <= start_c - SW'(1);
      req_ok_r   <= req_ok_c;
      wrap_r     <= (start_c != SW'(1));
    end
    if (cmd.issue) begin
      chk_row_r  <= row_r;
      chk_pass_r <= pass_r;
      chk_last_r <= last_c;
    end
    if (hit_c) begin
      win_row_r  <= chk_row_r;
      win_word_r <= rd_data_r | (WORD'(1) << hit_bit_c);
      win_slot_r <= {chk_row_r, hit_bit_c};
    end
    if (cmd.grant) begin
      out_data_r.assigned_slot <= SLOT_W'(win_slot_r);
      out_data_r.status        <= STAT_GRANTED;
    end else if (cmd.full) begin
      out_data_r.assigned_slot <= '0;
      out_data_r.status        <= STAT_FULL;
    end
  end

  always_comb begin
    sts            = '0;
    sts.clr_done   = (clr_ptr_r == RW'(ROWS - 1));
    sts.hit        = hit_c;
    sts.full       = chk_v_r && chk_last_r && !hit_c;
    sts.issue_done = done_r;
    sts.rel_ok     = req_ok_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_GRANTED) |-> out_data.assigned_slot != '0)
    else $error("granted slot is zero");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_FULL) |-> out_data.assigned_slot == '0)
    else $error("full result carries a slot");

  a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_GRANTED) |->
      32'(out_data.assigned_slot) <= 32'(n_r))
    else $error("granted slot above active slot count");

endmodule

/* sv/circular_first_free_slot_allocator.sv */
// Allocate: the search reads 32-slot memory rows (one a cycle), from 1 up to 34 rows at
// 1024 slots. A hit passes through a write state that sets the slot's flag and registers
// the grant; a full result is registered from the last check. The next request is taken
// at the end of the result's strobe cycle. Release: a read state, then a write state if
// in range; no result. After reset a clearing pass frees every slot; busy is high.
// Results last one cycle and cannot be held off; configuration writes are always taken.
module circular_first_free_slot_allocator #(
  parameter int MAX_SLOTS = ffsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  ffsa_pkg::ffsa_in_t           in_data,
  output logic                         out_valid,
  output ffsa_pkg::ffsa_out_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffsa_pkg::SLOT_W-1:0]  cfg_data
);
  import ffsa_pkg::*;

  ffsa_cmd_t cmd;
  ffsa_sts_t sts;

  assign cfg_ready = 1'b1;

  ffsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_data.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ffsa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffsa_pkg::*;

  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 5000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ffsa_in_t          in_data = '0;
  logic              out_valid;
  ffsa_out_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SLOT_W-1:0] cfg_data = '0;

  // Predicted allocator state: one occupied flag per slot, plus the slot count register.
  logic              taken [1:MAX_SLOTS_DEF];
  logic [SLOT_W-1:0] slot_limit;
  ffsa_out_t         grants_due [$];
  int                err_count = 0;
  int                stall_cycles = 0;
  logic              no_gaps = 1'b0;

  circular_first_free_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int live_slots();
    if (slot_limit == 0) begin
      return 1;
    end
    if (slot_limit > MAX_SLOTS_DEF) begin
      return MAX_SLOTS_DEF;
    end
    return int'(slot_limit);
  endfunction

  function automatic ffsa_out_t grant_slot(input logic [SLOT_W-1:0] from_slot);
    int        n;
    int        first;
    int        got;
    ffsa_out_t r;
    n = live_slots();
    first = (from_slot >= 1 && from_slot <= n) ? int'(from_slot) : 1;
    got = 0;
    for (int s = first; s <= n && got == 0; s++) begin
      if (!taken[s]) got = s;
    end
    for (int s = 1; s < first && got == 0; s++) begin
      if (!taken[s]) got = s;
    end
    if (got == 0) begin
      r.assigned_slot = '0;
      r.status        = STAT_FULL;
    end else begin
      taken[got]      = 1'b1;
      r.assigned_slot = SLOT_W'(got);
      r.status        = STAT_GRANTED;
    end
    return r;
  endfunction

  // Leaves start high on return, so a following call can present its beat without a gap.
  task automatic send_req(input logic func, input logic [SLOT_W-1:0] slot);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: gap = 0;
        8, 9, 10, 11, 12, 13, 14, 15, 16: gap = $urandom_range(1, 3);
        17, 18: gap = $urandom_range(4, 12);
        default: gap = $urandom_range(20, 60);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_data.func   <= func;
    in_data.requested_slot <= slot;
    do @(posedge clk); while (busy);
    if (func == FUNC_RELEASE) begin
      if (slot >= 1 && slot <= live_slots()) taken[slot] = 1'b0;
    end else begin
      grants_due.push_back(grant_slot(slot));
    end
  endtask

  // A release gives no result, so after the last grant the block may still be busy.
  task automatic write_slot_count(input logic [SLOT_W-1:0] value);
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    slot_limit = value;
  endtask

  always @(posedge clk) begin
    ffsa_out_t want;
    if (rst_n && out_valid) begin
      if (grants_due.size() == 0) begin
        $display("%0t: result with nothing expected: slot %0d status %0b",
                 $time, out_data.assigned_slot, out_data.status);
        err_count++;
      end else begin
        want = grants_due.pop_front();
        if (out_data.assigned_slot !== want.assigned_slot) begin
          $display("%0t: assigned_slot mismatch: expected %0d, actual %0d",
                   $time, want.assigned_slot, out_data.assigned_slot);
          err_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0b, actual %0b",
                   $time, want.status, out_data.status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with %0d grants outstanding", $time, grants_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Reset value of the slot count, out-of-range start slots and ignored releases.
  task automatic test_default_count();
    send_req(FUNC_ALLOC, 11'd0);
    send_req(FUNC_ALLOC, 11'd1024);
    send_req(FUNC_ALLOC, 11'd1024);
    send_req(FUNC_ALLOC, 11'd1025);
    send_req(FUNC_ALLOC, 11'd2047);
    send_req(FUNC_RELEASE, 11'd0);
    send_req(FUNC_RELEASE, 11'd1025);
    send_req(FUNC_RELEASE, 11'd2047);
    send_req(FUNC_RELEASE, 11'd1024);
    send_req(FUNC_RELEASE, 11'd1024);
    send_req(FUNC_ALLOC, 11'd1023);
    send_req(FUNC_ALLOC, 11'd1023);
    send_req(FUNC_ALLOC, 11'd1023);
    send_req(FUNC_ALLOC, 11'd31);
    send_req(FUNC_ALLOC, 11'd32);
    send_req(FUNC_ALLOC, 11'd33);
  endtask

  // A count of zero behaves as one slot, and a count above the maximum as the maximum.
  task automatic test_small_counts();
    write_slot_count(11'd0);
    send_req(FUNC_RELEASE, 11'd1);
    send_req(FUNC_ALLOC, 11'd1);
    send_req(FUNC_ALLOC, 11'd0);
    send_req(FUNC_ALLOC, 11'd5);
    send_req(FUNC_RELEASE, 11'd2);
    send_req(FUNC_RELEASE, 11'd1);
    send_req(FUNC_ALLOC, 11'd1);
    write_slot_count(11'd2);
    send_req(FUNC_ALLOC, 11'd2);
    send_req(FUNC_ALLOC, 11'd2);
    send_req(FUNC_ALLOC, 11'd2);
    write_slot_count(11'd2047);
    send_req(FUNC_ALLOC, 11'd1024);
    send_req(FUNC_ALLOC, 11'd1024);
  endtask

  // Flags above a lowered count are kept and come back into play when it is raised.
  task automatic test_count_lowered();
    write_slot_count(11'd24);
    repeat (25) send_req(FUNC_ALLOC, SLOT_W'($urandom_range(0, 30)));
    write_slot_count(11'd8);
    send_req(FUNC_RELEASE, 11'd3);
    send_req(FUNC_RELEASE, 11'd5);
    send_req(FUNC_RELEASE, 11'd20);
    send_req(FUNC_ALLOC, 11'd6);
    send_req(FUNC_ALLOC, 11'd6);
    send_req(FUNC_ALLOC, 11'd6);
    write_slot_count(11'd1);
    send_req(FUNC_ALLOC, 11'd1);
    write_slot_count(11'd1024);
    send_req(FUNC_ALLOC, 11'd20);
    send_req(FUNC_ALLOC, 11'd9);
  endtask

  task automatic test_random_traffic();
    logic [SLOT_W-1:0] counts [8];
    logic [SLOT_W-1:0] slot;
    int                n;
    int                pct_alloc;
    int                k;
    int                s;
    int                p;
    counts = '{11'd1024, 11'd2047, 11'd5, 11'd32, 11'd33, 11'd97, 11'd1100, 11'd1};
    counts[7] = SLOT_W'($urandom_range(1, 1024));
    for (p = 0; p < 8; p++) begin
      write_slot_count(counts[p]);
      n = live_slots();
      pct_alloc = (n <= 40) ? 55 : 80;
      no_gaps = (p == 2 || p == 5);
      repeat (62) begin
        if ($urandom_range(1, 100) <= pct_alloc) begin
          case ($urandom_range(0, 9))
            0: slot = '0;
            1: slot = SLOT_W'($urandom_range(n + 1, 2047));
            2, 3: slot = SLOT_W'($urandom_range(n > 8 ? n - 8 : 1, n));
            default: slot = SLOT_W'($urandom_range(1, n));
          endcase
          send_req(FUNC_ALLOC, slot);
        end else begin
          if ($urandom_range(0, 9) < 7) begin
            // Walk forward from a random slot to an occupied one, so releases mostly land.
            s = $urandom_range(1, n);
            for (k = 0; k < n && !taken[s]; k++) s = (s == n) ? 1 : s + 1;
            slot = SLOT_W'(s);
          end else begin
            slot = SLOT_W'($urandom_range(0, 2047));
          end
          send_req(FUNC_RELEASE, slot);
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    for (int i = 1; i <= MAX_SLOTS_DEF; i++) taken[i] = 1'b0;
    slot_limit = CNT_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_default_count();
    test_small_counts();
    test_count_lowered();
    test_random_traffic();
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
